FILE: rtl/table_waveform_generator_assert.svh
// ----------------------------------------------------------------------------
// table waveform generator assertion macros
// concurrent checks on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef TABLE_WAVEFORM_GENERATOR_ASSERT_SVH
`define TABLE_WAVEFORM_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TWG_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("twg assertion failed");

// next-cycle implication
`define TWG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("twg assertion failed");

`else

`define TWG_ASSERT(lbl, ante, cons)
`define TWG_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/twg_pkg.sv
// ----------------------------------------------------------------------------
// twg_pkg
// shared types, register indexes, waveform tables and defaults
// ----------------------------------------------------------------------------
`default_nettype none

package twg_pkg;

    localparam int TICK_RATE_DEF   = 32768;
    localparam int TABLE_DEPTH_DEF = 32;
    localparam int DIV_W_DEF       = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int FREQ_W     = 15;
    localparam int AMP_W      = 7;
    localparam int DAC_W      = 8;
    localparam int COUNT_W    = 16;
    localparam int TAB_IDX_W  = 5;
    localparam int PROD_W     = 15;

    localparam int AMP_MAX    = 100;
    localparam int PERIOD_MAX = 65535;
    localparam int FREQ_RST   = 100;

    localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREQUENCY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd2;

    typedef enum logic [1:0] {
        WAVE_CONST  = 2'd0,
        WAVE_SINE   = 2'd1,
        WAVE_SAW    = 2'd2,
        WAVE_SQUARE = 2'd3
    } t_wave;

    localparam logic [DAC_W-1:0] SINE_TAB [32] = '{
        8'd128, 8'd153, 8'd177, 8'd199, 8'd219, 8'd234, 8'd246, 8'd254,
        8'd255, 8'd254, 8'd246, 8'd234, 8'd219, 8'd199, 8'd177, 8'd153,
        8'd128, 8'd103, 8'd79,  8'd57,  8'd37,  8'd22,  8'd10,  8'd2,
        8'd0,   8'd2,   8'd10,  8'd22,  8'd37,  8'd57,  8'd79,  8'd103
    };

    localparam logic [DAC_W-1:0] SAW_TAB [32] = '{
        8'd0,   8'd8,   8'd16,  8'd25,  8'd33,  8'd41,  8'd49,  8'd58,
        8'd66,  8'd74,  8'd82,  8'd90,  8'd99,  8'd107, 8'd115, 8'd123,
        8'd132, 8'd140, 8'd148, 8'd156, 8'd165, 8'd173, 8'd181, 8'd189,
        8'd197, 8'd206, 8'd214, 8'd222, 8'd230, 8'd239, 8'd247, 8'd255
    };

    function automatic logic [DAC_W-1:0] wave_sample(t_wave w, logic [TAB_IDX_W-1:0] idx);
        logic [DAC_W-1:0] s;
        case (w)
            WAVE_CONST:  s = 8'd255;
            WAVE_SINE:   s = SINE_TAB[idx];
            WAVE_SAW:    s = SAW_TAB[idx];
            WAVE_SQUARE: s = idx[0] ? 8'd255 : 8'd0;
            default:     s = 8'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/table_waveform_generator.sv
// ----------------------------------------------------------------------------
// table_waveform_generator
// tick-driven table waveform generator with amplitude scaling
// ----------------------------------------------------------------------------
// One input word per time-base tick; each accepted word yields exactly one
// output word carrying the held converter value and a strobe that marks a new
// sample. A word that loads no sample goes from S_IDLE straight to S_DONE;
// a word that loads a sample passes these steps in order, each registered:
// - table lookup and amplitude product
// - scaling by a reciprocal multiply
// - the output register
// Input words are held off until a word has gone through S_DONE. A waveform
// or frequency write holds off input words while the shared bit-serial divider,
// W = max(clog2(TICK_RATE + 1), 16) bits wide, forms TICK_RATE / frequency and
// then divides by the sample count. An amplitude write takes effect at once. The
// next input word is taken while a finished output word still waits.
`default_nettype none

module table_waveform_generator #(
    parameter int TICK_RATE   = twg_pkg::TICK_RATE_DEF,
    parameter int TABLE_DEPTH = twg_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [twg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [twg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_tick,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [twg_pkg::DAC_W-1:0]      o_dac_value,
    output logic                           o_sample_strobe
);

    import twg_pkg::*;

    `include "table_waveform_generator_assert.svh"

    localparam int DIV_W = ($clog2(TICK_RATE + 1) > 16) ? $clog2(TICK_RATE + 1) : 16;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // floor(x / 100) for x up to 25500
    localparam int AMP_RECIP = 5243;
    localparam int AMP_SHIFT = 19;
    localparam int SCALE_W   = PROD_W + 13;

    localparam int FM_C_RAW  = TICK_RATE / 1 / 2;
    localparam int FM_T_RAW  = TICK_RATE / TABLE_DEPTH / 2;
    localparam int FM_S_RAW  = TICK_RATE / 2 / 2;
    localparam int FMAX_C    = (FM_C_RAW == 0) ? 1 : FM_C_RAW;
    localparam int FMAX_T    = (FM_T_RAW == 0) ? 1 : FM_T_RAW;
    localparam int FMAX_S    = (FM_S_RAW == 0) ? 1 : FM_S_RAW;
    localparam int RST_FREQ  = (FREQ_RST > FMAX_T) ? FMAX_T : FREQ_RST;
    localparam int RST_P_RAW = TICK_RATE / RST_FREQ / TABLE_DEPTH;
    localparam int RST_PER   = (RST_P_RAW == 0) ? 1 :
                               ((RST_P_RAW > PERIOD_MAX) ? PERIOD_MAX : RST_P_RAW);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PER1 = 6'b000010,
        S_PER2 = 6'b000100,
        S_MUL  = 6'b001000,
        S_SAMP = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    function automatic logic [DIV_W-1:0] f_fmax(t_wave w);
        logic [DIV_W-1:0] m;
        case (w)
            WAVE_CONST:  m = DIV_W'(FMAX_C);
            WAVE_SQUARE: m = DIV_W'(FMAX_S);
            default:     m = DIV_W'(FMAX_T);
        endcase
        return m;
    endfunction

    function automatic logic [DIV_W-1:0] f_samples(t_wave w);
        logic [DIV_W-1:0] n;
        case (w)
            WAVE_CONST:  n = DIV_W'(1);
            WAVE_SQUARE: n = DIV_W'(2);
            default:     n = DIV_W'(TABLE_DEPTH);
        endcase
        return n;
    endfunction

    function automatic logic [FREQ_W-1:0] f_sat_freq(logic [FREQ_W-1:0] f, t_wave w);
        logic [DIV_W-1:0]  m;
        logic [FREQ_W-1:0] r;
        m = f_fmax(w);
        if (f == '0) begin
            r = FREQ_W'(1);
        end else if (DIV_W'(f) > m) begin
            r = m[FREQ_W-1:0];
        end else begin
            r = f;
        end
        return r;
    endfunction

    t_state             r_state,     n_state;
    t_wave              r_wave,      n_wave;
    logic [FREQ_W-1:0]  r_freq,      n_freq;
    logic [AMP_W-1:0]   r_amp,       n_amp;
    logic [COUNT_W-1:0] r_count,     n_count;
    logic [COUNT_W-1:0] r_period,    n_period;
    logic [IDX_W-1:0]   r_idx,       n_idx;
    logic [DAC_W-1:0]   r_value,     n_value;
    logic               r_strobe,    n_strobe;
    logic               r_out_valid, n_out_valid;
    logic [DAC_W-1:0]   r_out_dac;
    logic               r_out_strobe;
    logic [PROD_W-1:0]  r_prod;
    logic               w_load;

    logic               w_div_start;
    logic [DIV_W-1:0]   w_div_dividend;
    logic [DIV_W-1:0]   w_div_divisor;
    logic               w_div_busy;
    logic               w_div_done;
    logic [DIV_W-1:0]   w_div_quo;

    logic [COUNT_W-1:0] w_cnt_inc;
    logic [DIV_W-1:0]   w_idx_inc;
    logic [PROD_W-1:0]  w_prod;
    logic [SCALE_W-1:0] w_scaled;
    logic               w_accept;

    assign w_cnt_inc = r_count + COUNT_W'(1);
    assign w_idx_inc = DIV_W'(r_idx) + DIV_W'(1);
    assign w_prod    = PROD_W'(wave_sample(r_wave, TAB_IDX_W'(r_idx))) * PROD_W'(r_amp);
    assign w_scaled  = SCALE_W'(r_prod) * SCALE_W'(AMP_RECIP);
    assign w_accept  = i_in_valid && !o_in_stall;

    assign o_in_stall = (r_state != S_IDLE) || i_cfg_we;

    always_comb begin
        n_state        = r_state;
        n_wave         = r_wave;
        n_freq         = r_freq;
        n_amp          = r_amp;
        n_count        = r_count;
        n_period       = r_period;
        n_idx          = r_idx;
        n_value        = r_value;
        n_strobe       = r_strobe;
        n_out_valid    = r_out_valid && i_out_stall;
        w_load         = 1'b0;
        w_div_start    = 1'b0;
        w_div_dividend = DIV_W'(TICK_RATE);
        w_div_divisor  = DIV_W'(r_freq);
        case (r_state)
            S_IDLE: begin
                if (i_cfg_we) begin
                    case (i_cfg_index)
                        REG_WAVEFORM: begin
                            n_wave        = t_wave'(i_cfg_data[1:0]);
                            n_idx         = '0;
                            n_freq        = f_sat_freq(r_freq, n_wave);
                            w_div_start   = 1'b1;
                            w_div_divisor = DIV_W'(n_freq);
                            n_state       = S_PER1;
                        end
                        REG_FREQUENCY: begin
                            n_freq        = f_sat_freq(i_cfg_data[FREQ_W-1:0], r_wave);
                            w_div_start   = 1'b1;
                            w_div_divisor = DIV_W'(n_freq);
                            n_state       = S_PER1;
                        end
                        REG_AMPLITUDE: begin
                            if (i_cfg_data[AMP_W-1:0] > AMP_W'(AMP_MAX)) begin
                                n_amp = AMP_W'(AMP_MAX);
                            end else begin
                                n_amp = i_cfg_data[AMP_W-1:0];
                            end
                        end
                        default: begin
                        end
                    endcase
                end else if (w_accept) begin
                    n_strobe = 1'b0;
                    n_state  = S_DONE;
                    if (i_tick) begin
                        if (w_cnt_inc >= r_period) begin
                            n_count = '0;
                            n_state = S_MUL;
                            if (w_idx_inc >= f_samples(r_wave)) begin
                                n_idx = '0;
                            end else begin
                                n_idx = w_idx_inc[IDX_W-1:0];
                            end
                        end else begin
                            n_count = w_cnt_inc;
                        end
                    end
                end
            end
            S_PER1: begin
                if (w_div_done) begin
                    w_div_start    = 1'b1;
                    w_div_dividend = w_div_quo;
                    w_div_divisor  = f_samples(r_wave);
                    n_state        = S_PER2;
                end
            end
            S_PER2: begin
                if (w_div_done) begin
                    if (w_div_quo == '0) begin
                        n_period = COUNT_W'(1);
                    end else if (w_div_quo > DIV_W'(PERIOD_MAX)) begin
                        n_period = COUNT_W'(PERIOD_MAX);
                    end else begin
                        n_period = w_div_quo[COUNT_W-1:0];
                    end
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                n_state = S_SAMP;
            end
            S_SAMP: begin
                n_value  = w_scaled[AMP_SHIFT +: DAC_W];
                n_strobe = 1'b1;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wave      <= WAVE_SINE;
            r_freq      <= FREQ_W'(RST_FREQ);
            r_amp       <= AMP_W'(AMP_MAX);
            r_count     <= '0;
            r_period    <= COUNT_W'(RST_PER);
            r_idx       <= '0;
            r_value     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wave      <= n_wave;
            r_freq      <= n_freq;
            r_amp       <= n_amp;
            r_count     <= n_count;
            r_period    <= n_period;
            r_idx       <= n_idx;
            r_value     <= n_value;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_strobe <= n_strobe;
        if (r_state == S_MUL) begin
            r_prod <= w_prod;
        end
        if (w_load) begin
            r_out_dac    <= r_value;
            r_out_strobe <= r_strobe;
        end
    end

    twg_div #(
        .W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    assign o_out_valid     = r_out_valid;
    assign o_dac_value     = r_out_dac;
    assign o_sample_strobe = r_out_strobe;

    `TWG_ASSERT(a_period_nz, 1'b1, r_period != '0)
    `TWG_ASSERT(a_amp_max, 1'b1, r_amp <= AMP_W'(AMP_MAX))
    `TWG_ASSERT(a_freq_rng, 1'b1, (r_freq != '0) && (DIV_W'(r_freq) <= f_fmax(r_wave)))
    `TWG_ASSERT(a_idx_rng, 1'b1, DIV_W'(r_idx) < f_samples(r_wave))
    `TWG_ASSERT(a_div_wait, (r_state == S_PER1) || (r_state == S_PER2), w_div_busy || w_div_done)

endmodule

`default_nettype wire

FILE: rtl/twg_div.sv
// ----------------------------------------------------------------------------
// twg_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module twg_div #(
    parameter int W = twg_pkg::DIV_W_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_busy,
    output logic         o_done,
    output logic [W-1:0] o_quotient
);

    `include "table_waveform_generator_assert.svh"

    localparam int CNT_W = $clog2(W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_dsr;

    logic [W:0]       w_shift;
    logic [W:0]       w_diff;
    logic             w_ge;
    logic             w_last;

    assign w_shift = {r_rem, r_quo[W-1]};
    assign w_diff  = w_shift - {1'b0, r_dsr};
    assign w_ge    = (w_shift >= {1'b0, r_dsr});
    assign w_last  = (r_cnt == CNT_W'(W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[W-1:0] : w_shift[W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    `TWG_ASSERT(a_start_idle, i_start, !r_busy)
    `TWG_ASSERT_NXT(a_start_busy, i_start, r_busy)
    `TWG_ASSERT(a_done_idle, r_done, !r_busy)

endmodule

`default_nettype wire
